// File: rtl/core/assert_macros.svh
// Assertion macros shared by the key binding table RTL.
// Depends on nothing; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KBT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define KBT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define KBT_ASSERT(lbl, clk, rst, prop)
`define KBT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/kbt_pkg.sv
// Package for the key binding table: sequencer states, codes and defaults.
// Depends on nothing.
`default_nettype none
package kbt_pkg;
   localparam int TABLE_DEPTH_DEF  = 32;
   localparam int NUM_CONTROLS_DEF = 64;

   localparam int KEY_W  = 16;
   localparam int CTL_W  = 6;

   localparam logic [2:0] MODE_REGISTER = 3'd0;
   localparam logic [2:0] MODE_EVENT    = 3'd1;
   localparam logic [2:0] MODE_READ     = 3'd2;
   localparam logic [2:0] MODE_CLEAR    = 3'd3;
   localparam logic [2:0] MODE_SNAPSHOT = 3'd4;

   localparam logic [1:0] EV_DOWN   = 2'd0;
   localparam logic [1:0] EV_TOGGLE = 2'd2;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_OTHER   = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;
   localparam logic [1:0] STAT_UNBOUND = 2'd3;

   localparam logic [1:0] CODE_OFF  = 2'd0;
   localparam logic [1:0] CODE_NEW  = 2'd1;
   localparam logic [1:0] CODE_HELD = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMPARE,
      ST_SHIFT,
      ST_SHIFT_WR,
      ST_EMIT,
      ST_SNAP
   } kbt_state_type;
endpackage
`default_nettype wire

// File: rtl/core/key_binding_table_control_state_top.sv
// Key binding table with sorted binding memory, binary search sequencer and control bits.
// Depends on kbt_pkg and assert_macros.svh.
// Each probe of the shared key comparator takes the search and compare states; an insert
// moves each shifted entry through a read and a write state, then writes the new one; read
// and clear go straight to emit. A snapshot sends one transfer per ready cycle, and the
// next request is taken in the cycle after the last result is staged. Reset clears count and bits.
`default_nettype none
`include "assert_macros.svh"
module key_binding_table_control_state_top #(
   parameter int TABLE_DEPTH  = kbt_pkg::TABLE_DEPTH_DEF,
   parameter int NUM_CONTROLS = kbt_pkg::NUM_CONTROLS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // key_code[15:0], control_id[21:16], event_kind[23:22]
   input  wire logic [2:0]  req_tuser,  // mode[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // found_control[5:0], control_bit[6], state_code[8:7]
   output logic [1:0]       rsp_tuser,  // status[1:0]
   output logic             rsp_tlast
);
   localparam int EW  = $clog2(TABLE_DEPTH + 1);
   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int CIW = (NUM_CONTROLS > 1) ? $clog2(NUM_CONTROLS) : 1;
   localparam int DW  = kbt_pkg::KEY_W + kbt_pkg::CTL_W;

   kbt_pkg::kbt_state_type state_ff, state_in;
   logic [2:0]                 mode_ff, mode_in;
   logic [kbt_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [kbt_pkg::CTL_W-1:0]  ctl_ff, ctl_in;
   logic [1:0]                 kind_ff, kind_in;
   logic [EW-1:0]              lo_ff, lo_in, hi_ff, hi_in, idx_ff, idx_in, used_ff, used_in;
   logic [AW-1:0]              mid_ff, mid_in;
   logic [CIW-1:0]             snap_ff, snap_in;
   logic [NUM_CONTROLS-1:0]    pressed_ff, pressed_in, prev_ff, prev_in;
   logic [1:0]                 res_status_ff, res_status_in;
   logic [kbt_pkg::CTL_W-1:0]  res_ctl_ff, res_ctl_in;
   logic                       res_bit_ff, res_bit_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 rsp_status_ff, rsp_status_in;
   logic [kbt_pkg::CTL_W-1:0]  rsp_ctl_ff, rsp_ctl_in;
   logic                       rsp_bit_ff, rsp_bit_in;
   logic [1:0]                 rsp_code_ff, rsp_code_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [DW-1:0]  mem [TABLE_DEPTH];
   logic [DW-1:0]  rd_data_ff;
   logic           mem_we;
   logic [AW-1:0]  mem_waddr, mem_raddr;
   logic [DW-1:0]  mem_wdata;

   logic [EW:0]               mid_sum;
   logic [AW-1:0]             mid_calc;
   logic [EW-1:0]             idx_dec;
   logic [kbt_pkg::KEY_W-1:0] rd_key;
   logic [kbt_pkg::CTL_W-1:0] rd_ctl;
   logic                      out_free;
   logic                      new_bit;
   logic                      snap_bit;

   function automatic logic ctl_ok(input logic [kbt_pkg::CTL_W-1:0] c);
      return {1'b0, c} < 7'(NUM_CONTROLS);
   endfunction

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc = mid_sum[AW:1];
   assign idx_dec  = idx_ff - EW'(1);
   assign rd_key   = rd_data_ff[DW-1:kbt_pkg::CTL_W];
   assign rd_ctl   = rd_data_ff[kbt_pkg::CTL_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign snap_bit = pressed_ff[snap_ff];

   assign req_tready = (state_ff == kbt_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_code_ff, rsp_bit_ff, rsp_ctl_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kbt_pkg::ST_IDLE;
         used_ff      <= '0;
         pressed_ff   <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         pressed_ff   <= pressed_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      ctl_ff        <= ctl_in;
      kind_ff       <= kind_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      idx_ff        <= idx_in;
      snap_ff       <= snap_in;
      res_status_ff <= res_status_in;
      res_ctl_ff    <= res_ctl_in;
      res_bit_ff    <= res_bit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ctl_ff    <= rsp_ctl_in;
      rsp_bit_ff    <= rsp_bit_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      ctl_in        = ctl_ff;
      kind_in       = kind_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      idx_in        = idx_ff;
      snap_in       = snap_ff;
      used_in       = used_ff;
      pressed_in    = pressed_ff;
      prev_in       = prev_ff;
      res_status_in = res_status_ff;
      res_ctl_in    = res_ctl_ff;
      res_bit_in    = res_bit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_ctl_in    = rsp_ctl_ff;
      rsp_bit_in    = rsp_bit_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff[AW-1:0];
      mem_wdata     = rd_data_ff;
      mem_raddr     = mid_calc;
      new_bit       = 1'b0;
      case (state_ff)
         kbt_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               mode_in = req_tuser;
               key_in  = req_tdata[15:0];
               ctl_in  = req_tdata[21:16];
               kind_in = req_tdata[23:22];
               lo_in   = '0;
               hi_in   = used_ff;
               snap_in = '0;
               case (req_tuser)
                  kbt_pkg::MODE_REGISTER, kbt_pkg::MODE_EVENT: begin
                     state_in = kbt_pkg::ST_SEARCH;
                  end
                  kbt_pkg::MODE_READ: begin
                     res_status_in = kbt_pkg::STAT_OK;
                     res_ctl_in    = req_tdata[21:16];
                     res_bit_in    = ctl_ok(req_tdata[21:16]) ?
                                     pressed_ff[req_tdata[16 +: CIW]] : 1'b0;
                     state_in      = kbt_pkg::ST_EMIT;
                  end
                  kbt_pkg::MODE_CLEAR: begin
                     pressed_in    = '0;
                     res_status_in = kbt_pkg::STAT_OK;
                     res_ctl_in    = '0;
                     res_bit_in    = 1'b0;
                     state_in      = kbt_pkg::ST_EMIT;
                  end
                  kbt_pkg::MODE_SNAPSHOT: begin
                     state_in = kbt_pkg::ST_SNAP;
                  end
                  default: begin
                     state_in = kbt_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         kbt_pkg::ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_calc;
               state_in = kbt_pkg::ST_COMPARE;
            end else if (mode_ff != kbt_pkg::MODE_REGISTER) begin
               res_status_in = kbt_pkg::STAT_UNBOUND;
               res_ctl_in    = '0;
               res_bit_in    = 1'b0;
               state_in      = kbt_pkg::ST_EMIT;
            end else if (used_ff >= EW'(TABLE_DEPTH)) begin
               res_status_in = kbt_pkg::STAT_FULL;
               res_ctl_in    = '0;
               res_bit_in    = 1'b0;
               state_in      = kbt_pkg::ST_EMIT;
            end else begin
               idx_in   = used_ff;
               state_in = kbt_pkg::ST_SHIFT;
            end
         end
         kbt_pkg::ST_COMPARE: begin
            if (rd_key == key_ff) begin
               res_ctl_in = rd_ctl;
               res_bit_in = 1'b0;
               if (mode_ff == kbt_pkg::MODE_REGISTER) begin
                  res_status_in = (rd_ctl == ctl_ff) ? kbt_pkg::STAT_OK : kbt_pkg::STAT_OTHER;
               end else begin
                  res_status_in = kbt_pkg::STAT_OK;
                  if (ctl_ok(rd_ctl)) begin
                     new_bit = (kind_ff == kbt_pkg::EV_TOGGLE) ?
                               !pressed_ff[rd_ctl[CIW-1:0]] : (kind_ff == kbt_pkg::EV_DOWN);
                     pressed_in[rd_ctl[CIW-1:0]] = new_bit;
                     res_bit_in = new_bit;
                  end
               end
               state_in = kbt_pkg::ST_EMIT;
            end else begin
               if (rd_key < key_ff) begin
                  lo_in = EW'(mid_ff) + EW'(1);
               end else begin
                  hi_in = EW'(mid_ff);
               end
               state_in = kbt_pkg::ST_SEARCH;
            end
         end
         kbt_pkg::ST_SHIFT: begin
            if (idx_ff > lo_ff) begin
               mem_raddr = idx_dec[AW-1:0];
               state_in  = kbt_pkg::ST_SHIFT_WR;
            end else begin
               mem_we        = 1'b1;
               mem_waddr     = lo_ff[AW-1:0];
               mem_wdata     = {key_ff, ctl_ff};
               used_in       = used_ff + EW'(1);
               res_status_in = kbt_pkg::STAT_OK;
               res_ctl_in    = ctl_ff;
               res_bit_in    = 1'b0;
               state_in      = kbt_pkg::ST_EMIT;
            end
         end
         kbt_pkg::ST_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[AW-1:0];
            mem_wdata = rd_data_ff;
            idx_in    = idx_dec;
            state_in  = kbt_pkg::ST_SHIFT;
         end
         kbt_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_ctl_in    = res_ctl_ff;
               rsp_bit_in    = res_bit_ff;
               rsp_code_in   = kbt_pkg::CODE_OFF;
               rsp_last_in   = 1'b1;
               state_in      = kbt_pkg::ST_IDLE;
            end
         end
         kbt_pkg::ST_SNAP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = kbt_pkg::STAT_OK;
               rsp_ctl_in    = kbt_pkg::CTL_W'(snap_ff);
               rsp_bit_in    = snap_bit;
               rsp_code_in   = !snap_bit ? kbt_pkg::CODE_OFF :
                               (prev_ff[snap_ff] ? kbt_pkg::CODE_HELD : kbt_pkg::CODE_NEW);
               rsp_last_in   = (snap_ff == CIW'(NUM_CONTROLS - 1));
               prev_in[snap_ff] = snap_bit;
               if (snap_ff == CIW'(NUM_CONTROLS - 1)) begin
                  state_in = kbt_pkg::ST_IDLE;
               end else begin
                  snap_in = snap_ff + CIW'(1);
               end
            end
         end
         default: begin
            state_in = kbt_pkg::ST_IDLE;
         end
      endcase
   end

   `KBT_ASSERT(a_used_in_range, clock, reset, used_ff <= EW'(TABLE_DEPTH))
   `KBT_ASSERT(a_probe_in_window, clock, reset,
      (state_ff != kbt_pkg::ST_COMPARE) || (EW'(mid_ff) < hi_ff && EW'(mid_ff) >= lo_ff))
   `KBT_ASSERT_NEXT(a_insert_counts, clock, reset,
      state_ff == kbt_pkg::ST_SHIFT && idx_ff == lo_ff,
      used_ff == $past(used_ff) + EW'(1))
endmodule
`default_nettype wire
